// ===== design/pol_pkg.sv =====
// Package for the positional ordered list: sizes, command and status codes,
// and the control/status structs between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pol_pkg;

  // Store size and derived widths
  localparam int unsigned Capacity = 32;
  localparam int unsigned IdxW     = $clog2(Capacity);
  localparam int unsigned CntW     = $clog2(Capacity + 1);
  localparam int unsigned FuncW    = 3;
  localparam int unsigned PosW     = 6;
  localparam int unsigned ValW     = 32;
  localparam int unsigned StatW    = 2;
  localparam int unsigned LenW     = 6;
  localparam int unsigned CmpW     = ((CntW > PosW) ? CntW : PosW) + 1;

  // Command codes; other codes are a no-op
  typedef enum logic [FuncW-1:0] {
    FUNC_INSERT    = 3'd0,
    FUNC_DELETE    = 3'd1,
    FUNC_DEL_FIRST = 3'd2,
    FUNC_DEL_LAST  = 3'd3,
    FUNC_READ_ALL  = 3'd4
  } func_e;

  // Result status codes
  typedef enum logic [StatW-1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_FULL   = 2'd2,
    ST_EMPTY  = 2'd3
  } status_e;

  // Controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_READ
  } state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic latch;      // capture the command beat
    logic exec;       // execute the command, load its single result
    logic read_load;  // load the next entry of a read-all
  } pol_ctrl_t;

  // Status from datapath to controller
  typedef struct packed {
    logic out_free;       // output register can take a result this cycle
    logic read_nonempty;  // latched command is read-all on a non-empty list
    logic read_last;      // read pointer is at the final entry
  } pol_stat_t;

endpackage

`default_nettype wire

// ===== design/pol_cmd_if.sv =====
// Command channel: valid/ready handshake with func, position and value.
// Depends on pol_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface pol_cmd_if;
  logic                                valid;
  logic                                ready;
  logic        [pol_pkg::FuncW-1:0]    func;
  logic        [pol_pkg::PosW-1:0]     position;
  logic signed [pol_pkg::ValW-1:0]     value;

  modport source (output valid, func, position, value, input ready);
  modport sink   (input valid, func, position, value, output ready);
endinterface

`default_nettype wire

// ===== design/pol_rsp_if.sv =====
// Result channel: valid/ready handshake with status, entry and length.
// Depends on pol_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface pol_rsp_if;
  logic                                valid;
  logic                                ready;
  logic        [pol_pkg::StatW-1:0]    status;
  logic signed [pol_pkg::ValW-1:0]     entry_value;
  logic                                entry_valid;
  logic        [pol_pkg::LenW-1:0]     length;
  logic                                last;

  modport source (output valid, status, entry_value, entry_valid, length, last,
                  input ready);
  modport sink   (input valid, status, entry_value, entry_valid, length, last,
                  output ready);
endinterface

`default_nettype wire

// ===== design/pol_ctrl.sv =====
// Controller for the positional ordered list: accepts a command, runs it,
// and steps the datapath through a read-all. Depends on pol_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pol_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cmd_valid_i,
  output logic                    cmd_ready_o,
  input  wire pol_pkg::pol_stat_t stat_i,
  output pol_pkg::pol_ctrl_t      ctrl_o
);

  pol_pkg::state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pol_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d     = state_q;
    cmd_ready_o = 1'b0;
    ctrl_o      = '0;
    case (state_q)
      pol_pkg::S_IDLE: begin
        cmd_ready_o = 1'b1;
        if (cmd_valid_i) begin
          ctrl_o.latch = 1'b1;
          state_d      = pol_pkg::S_EXEC;
        end
      end
      pol_pkg::S_EXEC: begin
        // hand a non-empty read-all to the read loop
        if (stat_i.read_nonempty) begin
          state_d = pol_pkg::S_READ;
        end else if (stat_i.out_free) begin
          ctrl_o.exec = 1'b1;
          state_d     = pol_pkg::S_IDLE;
        end
      end
      pol_pkg::S_READ: begin
        // one entry per free output slot
        if (stat_i.out_free) begin
          ctrl_o.read_load = 1'b1;
          if (stat_i.read_last) begin
            state_d = pol_pkg::S_IDLE;
          end
        end
      end
      default: begin
        state_d = pol_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== design/pol_datapath.sv =====
// Datapath for the positional ordered list: command latch, entry cells that
// shift at once for insert/delete, read pointer, result register. Depends on pol_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pol_datapath (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire pol_pkg::pol_ctrl_t                  ctrl_i,
  output pol_pkg::pol_stat_t                       stat_o,
  input  wire logic        [pol_pkg::FuncW-1:0]    func_i,
  input  wire logic        [pol_pkg::PosW-1:0]     position_i,
  input  wire logic signed [pol_pkg::ValW-1:0]     value_i,
  output logic                                     rsp_valid_o,
  input  wire logic                                rsp_ready_i,
  output logic             [pol_pkg::StatW-1:0]    status_o,
  output logic signed      [pol_pkg::ValW-1:0]     entry_value_o,
  output logic                                     entry_valid_o,
  output logic             [pol_pkg::LenW-1:0]     length_o,
  output logic                                     last_o
);

  localparam int unsigned Cap  = pol_pkg::Capacity;
  localparam int unsigned IdxW = pol_pkg::IdxW;
  localparam int unsigned CntW = pol_pkg::CntW;
  localparam int unsigned CmpW = pol_pkg::CmpW;

  // Latched command
  logic        [pol_pkg::FuncW-1:0] func_q;
  logic        [pol_pkg::PosW-1:0]  pos_q;
  logic signed [pol_pkg::ValW-1:0]  val_q;

  // List state
  logic signed [pol_pkg::ValW-1:0] entries_q [Cap];
  logic signed [pol_pkg::ValW-1:0] entries_d [Cap];
  logic [CntW-1:0] count_q, count_d;
  logic [IdxW-1:0] rd_idx_q, rd_idx_d;

  // Result register
  logic                          rsp_valid_q, rsp_valid_d;
  pol_pkg::status_e              status_q, status_d;
  logic signed [pol_pkg::ValW-1:0] evalue_q, evalue_d;
  logic                          evalid_q, evalid_d;
  logic [pol_pkg::LenW-1:0]      len_q, len_d;
  logic                          last_q, last_d;

  // Execution helpers
  pol_pkg::status_e st;
  logic [CmpW-1:0]  pos_ext, cnt_ext;
  logic [IdxW-1:0]  ins_idx, del_idx;
  logic             do_ins, do_del;

  assign pos_ext = CmpW'(pos_q);
  assign cnt_ext = CmpW'(count_q);
  assign ins_idx = IdxW'(pos_ext - CmpW'(1));

  // Status toward the controller
  assign stat_o.out_free      = !rsp_valid_q || rsp_ready_i;
  assign stat_o.read_nonempty = (func_q == pol_pkg::FUNC_READ_ALL) && (count_q != '0);
  assign stat_o.read_last     = (CntW'(rd_idx_q) + CntW'(1)) == count_q;

  // Decode the latched command
  always_comb begin
    st      = pol_pkg::ST_OK;
    do_ins  = 1'b0;
    do_del  = 1'b0;
    del_idx = ins_idx;
    count_d = count_q;
    case (func_q)
      pol_pkg::FUNC_INSERT: begin
        if (pos_ext == '0 || pos_ext > cnt_ext + CmpW'(1)) begin
          st = pol_pkg::ST_BADPOS;
        end else if (cnt_ext >= CmpW'(Cap)) begin
          st = pol_pkg::ST_FULL;
        end else begin
          do_ins  = 1'b1;
          count_d = count_q + CntW'(1);
        end
      end
      pol_pkg::FUNC_DELETE: begin
        if (pos_ext == '0 || pos_ext > cnt_ext) begin
          st = pol_pkg::ST_BADPOS;
        end else begin
          do_del  = 1'b1;
          count_d = count_q - CntW'(1);
        end
      end
      pol_pkg::FUNC_DEL_FIRST: begin
        if (count_q == '0) begin
          st = pol_pkg::ST_EMPTY;
        end else begin
          do_del  = 1'b1;
          del_idx = '0;
          count_d = count_q - CntW'(1);
        end
      end
      pol_pkg::FUNC_DEL_LAST: begin
        if (count_q == '0) begin
          st = pol_pkg::ST_EMPTY;
        end else begin
          count_d = count_q - CntW'(1);
        end
      end
      pol_pkg::FUNC_READ_ALL: begin
        // only the empty case reaches execution
        st = pol_pkg::ST_EMPTY;
      end
      default: begin
        st = pol_pkg::ST_OK;
      end
    endcase
  end

  // Shift the cells for insert and delete
  always_comb begin
    entries_d = entries_q;
    if (ctrl_i.exec && do_ins) begin
      for (int i = 1; i < Cap; i++) begin
        if (IdxW'(i) > ins_idx) begin
          entries_d[i] = entries_q[i-1];
        end
      end
      entries_d[ins_idx] = val_q;
    end else if (ctrl_i.exec && do_del) begin
      for (int i = 0; i < Cap - 1; i++) begin
        if (IdxW'(i) >= del_idx) begin
          entries_d[i] = entries_q[i+1];
        end
      end
    end
  end

  // Read pointer
  always_comb begin
    rd_idx_d = rd_idx_q;
    if (ctrl_i.latch) begin
      rd_idx_d = '0;
    end else if (ctrl_i.read_load) begin
      rd_idx_d = rd_idx_q + IdxW'(1);
    end
  end

  // Result register: load on exec or read, drop when taken
  always_comb begin
    rsp_valid_d = rsp_valid_q;
    status_d    = status_q;
    evalue_d    = evalue_q;
    evalid_d    = evalid_q;
    len_d       = len_q;
    last_d      = last_q;
    if (ctrl_i.exec) begin
      rsp_valid_d = 1'b1;
      status_d    = st;
      evalue_d    = '0;
      evalid_d    = 1'b0;
      len_d       = pol_pkg::LenW'(count_d);
      last_d      = 1'b1;
    end else if (ctrl_i.read_load) begin
      rsp_valid_d = 1'b1;
      status_d    = pol_pkg::ST_OK;
      evalue_d    = entries_q[rd_idx_q];
      evalid_d    = 1'b1;
      len_d       = pol_pkg::LenW'(count_q);
      last_d      = stat_o.read_last;
    end else if (rsp_ready_i) begin
      rsp_valid_d = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (ctrl_i.exec) begin
        count_q <= count_d;
      end
      rsp_valid_q <= rsp_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (ctrl_i.latch) begin
      func_q <= func_i;
      pos_q  <= position_i;
      val_q  <= value_i;
    end
    entries_q <= entries_d;
    rd_idx_q  <= rd_idx_d;
    status_q  <= status_d;
    evalue_q  <= evalue_d;
    evalid_q  <= evalid_d;
    len_q     <= len_d;
    last_q    <= last_d;
  end

  assign rsp_valid_o   = rsp_valid_q;
  assign status_o      = status_q;
  assign entry_value_o = evalue_q;
  assign entry_valid_o = evalid_q;
  assign length_o      = len_q;
  assign last_o        = last_q;

endmodule

`default_nettype wire

// ===== design/positional_ordered_list.sv =====
// Top level of the positional ordered list: joins controller and datapath
// to the command and result channels. Depends on pol_pkg, pol_cmd_if, pol_rsp_if.
//
//   channel  dir  handshake       payload
//   cmd_i    in   valid / ready   func, position, value
//   rsp_o    out  valid / ready   status, entry_value, entry_valid, length, last
//
// A command is latched when its beat is accepted and runs in S_EXEC. Insert and
// delete shift the later cells at once as the command runs. Read-all emits one beat
// per stored entry, one per cycle while the result channel takes them.
// Reset empties the list; no clearing pass is needed. A stalled result holds
// the controller; the next command is accepted while the last result waits.
`timescale 1ns / 1ps
`default_nettype none

module positional_ordered_list (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  pol_cmd_if.sink   cmd_i,
  pol_rsp_if.source rsp_o
);

  pol_pkg::pol_ctrl_t ctrl;
  pol_pkg::pol_stat_t stat;

  // Sequencer
  pol_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_i.valid),
    .cmd_ready_o (cmd_i.ready),
    .stat_i      (stat),
    .ctrl_o      (ctrl)
  );

  // List storage and result register
  pol_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (ctrl),
    .stat_o        (stat),
    .func_i        (cmd_i.func),
    .position_i    (cmd_i.position),
    .value_i       (cmd_i.value),
    .rsp_valid_o   (rsp_o.valid),
    .rsp_ready_i   (rsp_o.ready),
    .status_o      (rsp_o.status),
    .entry_value_o (rsp_o.entry_value),
    .entry_valid_o (rsp_o.entry_valid),
    .length_o      (rsp_o.length),
    .last_o        (rsp_o.last)
  );

endmodule

`default_nettype wire
